FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, switched off while reset is low
`define FKVS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on clk that also holds through reset
`define FKVS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/fkvs_pkg.sv
`timescale 1ns / 1ps

package fkvs_pkg;

  // width of the internal scan address
  localparam int ADDR_BITS = 24;
  // width of the configuration registers and of the address fields on the ports
  localparam int CFG_W     = 24;
  // next-address sum, one bit above the wider of the two
  localparam int SUM_W     = ((ADDR_BITS > CFG_W) ? ADDR_BITS : CFG_W) + 1;
  // entry size in bytes, at most 4 + 256
  localparam int ENT_W     = 9;
  localparam int ID_W      = 8;
  localparam int LEN_W     = 8;
  localparam int KEY_W     = 7;
  localparam int NUM_KEYS  = 1 << KEY_W;
  localparam int DEAD_W    = 24;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  // paddr bit that selects between the two registers
  localparam int REG_SEL_BIT = 2;

  localparam logic REG_REGION_BASE = 1'b0;
  localparam logic REG_LOG_END     = 1'b1;

  localparam logic [DEAD_W-1:0] DEAD_MAX = '1;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_RESUME = 2'd1,
    REQ_HEADER = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_READ      = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_CORRUPT   = 2'd3
  } scan_status_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ID_W-1:0]  target_id;
    logic [LEN_W-1:0] hdr_prev_len;
    logic [LEN_W-1:0] hdr_len;
    logic [ID_W-1:0]  hdr_id;
  } item_t;

  typedef struct packed {
    scan_status_t      status;
    logic [CFG_W-1:0]  read_addr;
    logic [LEN_W-1:0]  entry_len;
    logic [ID_W-1:0]   entry_id;
    logic [DEAD_W-1:0] reclaimable;
    logic [KEY_W-1:0]  top_key;
    logic              orphan_keys;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] region_base;
    logic [CFG_W-1:0] log_end;
  } cfg_t;

  // header word plus payload padded to a whole word
  function automatic logic [ENT_W-1:0] entry_bytes(input logic [LEN_W-1:0] len);
    logic [ENT_W-1:0] padded;
    padded = ENT_W'(len) + ENT_W'(3);
    return {padded[ENT_W-1:2], 2'b00} + ENT_W'(4);
  endfunction

endpackage

FILE: rtl/core/flash_kv_log_header_scanner_top.sv
`timescale 1ns / 1ps
// channel  | direction | handshake             | payload
// in_      | input     | in_tvalid/in_tready   | tuser req_type, tdata header fields
// out_     | output    | out_tvalid/out_tready | tuser status, tdata scan result
// cfg_     | input     | psel/penable/pwrite   | region_base at 0x0, log_end at 0x4
//
// one request per cycle while out_tready keeps the result register free; the
// state update is one combinational loop; items pass input, then result register
// reset is synchronous on rst_n low and clears all scan state and both valid flags
// a stalled result holds in the result register while the next request waits
// in the input register; a request that yields no result still frees its slot
`include "assert_macros.svh"

module flash_kv_log_header_scanner_top
  import fkvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input transfer
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,  // target_id, hdr_prev_len, hdr_len, hdr_id
  input  logic [1:0]         in_tuser,  // req_type
  // result transfer
  output logic               out_tvalid,
  input  logic               out_tready,
  // read_addr, entry_len, entry_id, reclaimable, top_key, orphan_keys
  output logic [71:0]        out_tdata,
  output logic [1:0]         out_tuser, // status
  // configuration
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  cfg_t    cfg;
  logic    item_valid;
  item_t   item;
  logic    item_take;
  logic    res_valid;
  result_t res;
  logic    is_corrupt;
  logic    is_not_found;
  logic    is_found;
  logic    at_log_end;
  logic    entry_clear;

  fkvs_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fkvs_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  fkvs_scan_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (out_tready)
  );

  // result packing, lowest field first
  assign out_tvalid = res_valid;
  assign out_tuser  = res.status;
  assign out_tdata  = {res.orphan_keys, res.top_key, res.reclaimable,
                       res.entry_id, res.entry_len, res.read_addr};

  // terms for the checks
  assign is_corrupt   = out_tvalid && (out_tuser == ST_CORRUPT);
  assign is_not_found = out_tvalid && (out_tuser == ST_NOT_FOUND);
  assign is_found     = out_tvalid && (out_tuser == ST_FOUND);
  assign at_log_end   = (res.read_addr == cfg.log_end);
  assign entry_clear  = (res.entry_len == '0) && (res.entry_id == '0);

  // checks
  `FKVS_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `FKVS_ASSERT_RST(a_corrupt_at_end, is_corrupt |-> at_log_end, "corrupt result off log end")
  `FKVS_ASSERT_RST(a_not_found_clear, is_not_found |-> entry_clear, "not found with an entry")
  `FKVS_ASSERT_RST(a_found_has_id, is_found |-> res.entry_id != '0, "found result with zero id")

endmodule

FILE: rtl/core/fkvs_cfg_regs.sv
`timescale 1ns / 1ps

module fkvs_cfg_regs
  import fkvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready,
  output cfg_t               cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register write on the access phase
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_paddr[REG_SEL_BIT])
        REG_REGION_BASE: cfg_nxt.region_base = cfg_pwdata[CFG_W-1:0];
        REG_LOG_END:     cfg_nxt.log_end     = cfg_pwdata[CFG_W-1:0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_paddr[REG_SEL_BIT])
      REG_REGION_BASE: cfg_prdata = PDATA_W'(cfg_r.region_base);
      REG_LOG_END:     cfg_prdata = PDATA_W'(cfg_r.log_end);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/fkvs_in_reg.sv
`timescale 1ns / 1ps

module fkvs_in_reg
  import fkvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  output logic        item_valid,
  output item_t       item,
  input  logic        item_take
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  // stage is free when empty or when the core takes its item this cycle
  assign in_tready = !valid_r || item_take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.req_type     <= in_tuser;
      item_r.target_id    <= in_tdata[7:0];
      item_r.hdr_prev_len <= in_tdata[15:8];
      item_r.hdr_len      <= in_tdata[23:16];
      item_r.hdr_id       <= in_tdata[31:24];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: rtl/core/fkvs_scan_core.sv
`timescale 1ns / 1ps

module fkvs_scan_core
  import fkvs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_take,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);

  logic [ADDR_BITS-1:0] scan_addr_r, scan_addr_nxt;
  logic [LEN_W-1:0]     cur_len_r, cur_len_nxt;
  logic [ID_W-1:0]      cur_id_r, cur_id_nxt;
  logic [ID_W-1:0]      seek_id_r, seek_id_nxt;
  logic [NUM_KEYS-1:0]  key_map_r, key_map_nxt;
  logic [DEAD_W-1:0]    dead_r, dead_nxt;
  logic [KEY_W-1:0]     top_key_r, top_key_nxt;
  logic                 waiting_r, waiting_nxt;
  logic                 res_valid_r, res_valid_nxt;
  result_t              res_r;

  logic                 emit;
  logic                 do_adv;
  scan_status_t         status;
  logic [SUM_W-1:0]     next_sum;
  logic [DEAD_W:0]      dead_sum;
  logic [ADDR_BITS-1:0] adv_base;

  // one item per cycle while the result register is free or being drained
  assign item_take = item_valid && (!res_valid_r || res_ready);

  // state update for one request
  always_comb begin
    scan_addr_nxt = scan_addr_r;
    cur_len_nxt   = cur_len_r;
    cur_id_nxt    = cur_id_r;
    seek_id_nxt   = seek_id_r;
    key_map_nxt   = key_map_r;
    dead_nxt      = dead_r;
    top_key_nxt   = top_key_r;
    waiting_nxt   = waiting_r;
    emit          = 1'b0;
    do_adv        = 1'b0;
    status        = ST_READ;
    dead_sum      = '0;
    if (item_take) begin
      unique case (req_kind_t'(item.req_type))
        REQ_START: begin
          scan_addr_nxt = ADDR_BITS'(cfg.region_base);
          cur_len_nxt   = '0;
          cur_id_nxt    = '0;
          key_map_nxt   = '0;
          dead_nxt      = '0;
          top_key_nxt   = '0;
          waiting_nxt   = 1'b0;
          seek_id_nxt   = item.target_id;
          do_adv        = 1'b1;
        end
        REQ_RESUME: begin
          seek_id_nxt = item.target_id;
          if (waiting_r) begin
            // ask again for the outstanding header
            emit   = 1'b1;
            status = ST_READ;
          end else begin
            do_adv = 1'b1;
          end
        end
        REQ_HEADER: begin
          if (waiting_r) begin
            waiting_nxt = 1'b0;
            cur_len_nxt = item.hdr_len;
            cur_id_nxt  = item.hdr_id;
            if (item.hdr_prev_len != cur_len_r) begin
              // broken back link
              scan_addr_nxt = ADDR_BITS'(cfg.log_end);
              emit          = 1'b1;
              status        = ST_CORRUPT;
            end else if (item.hdr_id != '0) begin
              if (!item.hdr_id[ID_W-1]) begin
                // key definition
                if (item.hdr_id[KEY_W-1:0] > top_key_r) begin
                  top_key_nxt = item.hdr_id[KEY_W-1:0];
                end
                key_map_nxt[item.hdr_id[KEY_W-1:0]] = 1'b1;
                if (seek_id_r == '0) begin
                  seek_id_nxt = item.hdr_id;
                end
              end else begin
                // value entry
                key_map_nxt[item.hdr_id[KEY_W-1:0]] = 1'b0;
              end
              if (item.hdr_id == seek_id_nxt) begin
                emit   = 1'b1;
                status = ST_FOUND;
              end else begin
                do_adv = 1'b1;
              end
            end else begin
              // deleted entry, saturating byte count
              dead_sum = (DEAD_W + 1)'(dead_r) + (DEAD_W + 1)'(entry_bytes(item.hdr_len));
              dead_nxt = dead_sum[DEAD_W] ? DEAD_MAX : dead_sum[DEAD_W-1:0];
              do_adv   = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // step to the next header or stop at the end of the log
    adv_base = scan_addr_nxt;
    next_sum = SUM_W'(adv_base) + SUM_W'(entry_bytes(cur_len_nxt));
    if (do_adv) begin
      emit = 1'b1;
      if (next_sum < SUM_W'(cfg.log_end)) begin
        scan_addr_nxt = next_sum[ADDR_BITS-1:0];
        waiting_nxt   = 1'b1;
        status        = ST_READ;
      end else begin
        cur_len_nxt = '0;
        cur_id_nxt  = '0;
        waiting_nxt = 1'b0;
        status      = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      cur_len_r   <= '0;
      cur_id_r    <= '0;
      seek_id_r   <= '0;
      key_map_r   <= '0;
      dead_r      <= '0;
      top_key_r   <= '0;
      waiting_r   <= 1'b0;
    end else begin
      scan_addr_r <= scan_addr_nxt;
      cur_len_r   <= cur_len_nxt;
      cur_id_r    <= cur_id_nxt;
      seek_id_r   <= seek_id_nxt;
      key_map_r   <= key_map_nxt;
      dead_r      <= dead_nxt;
      top_key_r   <= top_key_nxt;
      waiting_r   <= waiting_nxt;
    end
  end

  // result register
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (item_take && emit) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      res_r.status      <= status;
      res_r.read_addr   <= CFG_W'(scan_addr_nxt);
      res_r.entry_len   <= cur_len_nxt;
      res_r.entry_id    <= cur_id_nxt;
      res_r.reclaimable <= dead_nxt;
      res_r.top_key     <= top_key_nxt;
      res_r.orphan_keys <= |key_map_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: dv/tb_flash_kv_log_header_scanner_top.sv
`timescale 1ns / 1ps

module tb_flash_kv_log_header_scanner_top;
  import fkvs_pkg::*;

  localparam int CYCLE_LIMIT     = 2000000;
  localparam int RANDOM_ITEMS    = 1900;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DIR_ROWS        = 24;
  // the scan window is programmed before this row of the directed table
  localparam int DIR_CFG_ROW     = 4;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_REGION_BASE = {REG_REGION_BASE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_LOG_END     = {REG_LOG_END, 2'b00};
  localparam result_t NO_RESULT = '0;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t res;
  } probe_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [31:0]        in_tdata;
  logic [1:0]         in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [71:0]        out_tdata;
  logic [1:0]         out_tuser;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  // scanner model state
  logic [CFG_W-1:0]    win_base;
  logic [CFG_W-1:0]    win_end;
  logic [CFG_W-1:0]    walk_addr;
  logic [LEN_W-1:0]    ent_len;
  logic [ID_W-1:0]     ent_id;
  logic [ID_W-1:0]     seek_id;
  logic [NUM_KEYS-1:0] keys_unvalued;
  logic [DEAD_W-1:0]   dead_total;
  logic [KEY_W-1:0]    top_key_id;
  logic                hdr_due;

  result_t expected_results[$];
  probe_t  dir_rows [DIR_ROWS];
  int      mismatches;
  int      cycle_count;
  bit      calm;
  bit      hold_off_req;

  flash_kv_log_header_scanner_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatches++;
  endtask

  function automatic item_t mk(input logic [1:0] kind, input logic [7:0] mid,
                               input logic [7:0] prev, input logic [7:0] len,
                               input logic [7:0] id);
    return '{kind, mid, prev, len, id};
  endfunction

  // header word plus payload rounded up to a word
  function automatic logic [ENT_W-1:0] footprint(input logic [LEN_W-1:0] len);
    logic [ENT_W-1:0] rounded;
    rounded = (ENT_W'(len) + ENT_W'(3)) & ~ENT_W'(3);
    return rounded + ENT_W'(4);
  endfunction

  function automatic result_t snapshot(input scan_status_t st);
    result_t r;
    r.status      = st;
    r.read_addr   = walk_addr;
    r.entry_len   = ent_len;
    r.entry_id    = ent_id;
    r.reclaimable = dead_total;
    r.top_key     = top_key_id;
    r.orphan_keys = |keys_unvalued;
    return r;
  endfunction

  // ask for the next header, or stop with not found at or past the log end
  task automatic step_on(output result_t r);
    logic [SUM_W-1:0] next;
    next = SUM_W'(walk_addr) + SUM_W'(footprint(ent_len));
    if (next < SUM_W'(win_end)) begin
      walk_addr = next[CFG_W-1:0];
      hdr_due   = 1'b1;
      r = snapshot(ST_READ);
    end else begin
      ent_len = '0;
      ent_id  = '0;
      hdr_due = 1'b0;
      r = snapshot(ST_NOT_FOUND);
    end
  endtask

  // one accepted request through the scanner model
  task automatic scan_step(input item_t it, output bit has, output result_t r);
    logic [LEN_W-1:0] prev_want;
    logic [SUM_W-1:0] dead_sum;
    has = 1'b1;
    r   = NO_RESULT;
    case (it.req_type)
      REQ_START: begin
        walk_addr     = win_base;
        ent_len       = '0;
        ent_id        = '0;
        keys_unvalued = '0;
        dead_total    = '0;
        top_key_id    = '0;
        hdr_due       = 1'b0;
        seek_id       = it.target_id;
        step_on(r);
      end
      REQ_RESUME: begin
        seek_id = it.target_id;
        // an outstanding read is asked for again
        if (hdr_due) r = snapshot(ST_READ);
        else step_on(r);
      end
      REQ_HEADER: begin
        if (!hdr_due) begin
          has = 1'b0;
        end else begin
          hdr_due   = 1'b0;
          prev_want = ent_len;
          ent_len   = it.hdr_len;
          ent_id    = it.hdr_id;
          if (it.hdr_prev_len != prev_want) begin
            walk_addr = win_end;
            r = snapshot(ST_CORRUPT);
          end else if (it.hdr_id == '0) begin
            // deleted entry, saturating byte count
            dead_sum   = SUM_W'(dead_total) + SUM_W'(footprint(it.hdr_len));
            dead_total = (dead_sum > SUM_W'(DEAD_MAX)) ? DEAD_MAX : dead_sum[DEAD_W-1:0];
            step_on(r);
          end else begin
            if (!it.hdr_id[7]) begin
              if (it.hdr_id[KEY_W-1:0] > top_key_id) top_key_id = it.hdr_id[KEY_W-1:0];
              keys_unvalued[it.hdr_id[KEY_W-1:0]] = 1'b1;
              if (seek_id == '0) seek_id = it.hdr_id;
            end else begin
              keys_unvalued[it.hdr_id[KEY_W-1:0]] = 1'b0;
            end
            if (it.hdr_id == seek_id) r = snapshot(ST_FOUND);
            else step_on(r);
          end
        end
      end
      default: has = 1'b0;
    endcase
  endtask

  // offer one request, wait for the transfer, then log what it should give
  task automatic push_request(input item_t it, input bit typed, input result_t typed_res,
                              output bit has);
    result_t r;
    while (!calm && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.req_type;
    in_tdata  <= {it.hdr_id, it.hdr_len, it.hdr_prev_len, it.target_id};
    do begin
      @(posedge clk);
    end while (!in_tready);
    scan_step(it, has, r);
    if (has) expected_results.push_back(typed ? typed_res : r);
  endtask

  // apb write, then read back
  task automatic program_register(input logic [PADDR_W-1:0] addr,
                                  input logic [CFG_W-1:0] value);
    logic [CFG_W-1:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= {8'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    if (addr == ADDR_REGION_BASE) win_base = value;
    else win_end = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_pready);
    readback = cfg_prdata[CFG_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== value) note_mismatch("register readback", 32'(readback), 32'(value));
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] lim);
    drain();
    program_register(ADDR_REGION_BASE, base);
    program_register(ADDR_LOG_END, lim);
  endtask

  // half the time a small pool so values meet their keys
  function automatic logic [7:0] pick_key();
    if ($urandom_range(1) != 0) return 8'($urandom_range(1, 12));
    return 8'($urandom_range(1, 127));
  endfunction

  function automatic logic [7:0] pick_match();
    int m;
    m = $urandom_range(99);
    if (m < 25) return 8'h00;
    if (m < 40) return 8'hff;
    if (m < 75) return pick_key();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_header_id();
    int m;
    m = $urandom_range(99);
    if (m < 20) return 8'h00;
    if (m < 45) return pick_key();
    if (m < 75) return pick_key() | 8'h80;
    if (m < 85 && seek_id != '0) return seek_id;
    return 8'($urandom);
  endfunction

  // mostly well-formed chain walks, some noise and broken links
  task automatic pick_request(output item_t it);
    int r;
    r  = $urandom_range(99);
    it = mk(REQ_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    if (hdr_due) begin
      if (r < 88) begin
        it.req_type = REQ_HEADER;
        if ($urandom_range(99) < 95) it.hdr_prev_len = ent_len;
        if ($urandom_range(99) < 12) it.hdr_len = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
        it.hdr_id = pick_header_id();
      end else if (r < 94) begin
        it.req_type  = REQ_RESUME;
        it.target_id = pick_match();
      end else if (r < 97) begin
        it.req_type  = REQ_START;
        it.target_id = pick_match();
      end
    end else begin
      if (r < 55) begin
        it.req_type  = REQ_START;
        it.target_id = pick_match();
      end else if (r < 80) begin
        it.req_type  = REQ_RESUME;
        it.target_id = pick_match();
      end else if (r < 92) begin
        it.req_type = REQ_HEADER;
      end
    end
  endtask

  task automatic run_random_phase(input int target, input bit with_hold);
    int      produced;
    item_t   it;
    bit      has;
    produced = 0;
    while (produced < target) begin
      pick_request(it);
      push_request(it, 1'b0, NO_RESULT, has);
      produced++;
      if (with_hold && produced == 60) hold_off_req = 1'b1;
    end
  endtask

  // a run of long deleted entries up to the top of the address space
  task automatic fill_reclaim();
    bit has;
    set_window(24'hfff000, 24'hffffff);
    calm = 1'b1;
    push_request(mk(REQ_START, 8'hff, 8'h00, 8'h00, 8'h00), 1'b0, NO_RESULT, has);
    while (hdr_due)
      push_request(mk(REQ_HEADER, 8'($urandom), ent_len, 8'hff, 8'h00), 1'b0, NO_RESULT, has);
    calm = 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready   <= 1'b0;
        hold_off_req = 1'b0;
        for (int n = 1; n < HOLD_OFF_CYCLES; n++) @(posedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  // result checker
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected transfer", 32'(out_tuser), 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.status)
            note_mismatch("status", 32'(out_tuser), 32'(want.status));
          if (out_tdata[23:0] !== want.read_addr)
            note_mismatch("read_addr", 32'(out_tdata[23:0]), 32'(want.read_addr));
          if (out_tdata[31:24] !== want.entry_len)
            note_mismatch("entry_len", 32'(out_tdata[31:24]), 32'(want.entry_len));
          if (out_tdata[39:32] !== want.entry_id)
            note_mismatch("entry_id", 32'(out_tdata[39:32]), 32'(want.entry_id));
          if (out_tdata[63:40] !== want.reclaimable)
            note_mismatch("reclaimable", 32'(out_tdata[63:40]), 32'(want.reclaimable));
          if (out_tdata[70:64] !== want.top_key)
            note_mismatch("top_key", 32'(out_tdata[70:64]), 32'(want.top_key));
          if (out_tdata[71] !== want.orphan_keys)
            note_mismatch("orphan_keys", 32'(out_tdata[71]), 32'(want.orphan_keys));
        end
      end
    end
  end

  // main sequence
  initial begin
    bit               has;
    int               per_phase;
    logic [CFG_W-1:0] base;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    mismatches    = 0;
    calm          = 1'b0;
    hold_off_req  = 1'b0;
    win_base      = '0;
    win_end       = '0;
    walk_addr     = '0;
    ent_len       = '0;
    ent_id        = '0;
    seek_id       = '0;
    keys_unvalued = '0;
    dead_total    = '0;
    top_key_id    = '0;
    hdr_due       = 1'b0;
    per_phase     = RANDOM_ITEMS / 6;

    // directed rows; the first ones run on the reset window
    dir_rows = '{
      '{mk(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
        '{ST_NOT_FOUND, 24'h000000, 8'h00, 8'h00, 24'h000000, 7'h00, 1'b0}},
      '{mk(REQ_HEADER, 8'hff, 8'hff, 8'hff, 8'hff), 1'b0, NO_RESULT},
      '{mk(REQ_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff), 1'b0, NO_RESULT},
      '{mk(REQ_RESUME, 8'h05, 8'h00, 8'h00, 8'h00), 1'b1,
        '{ST_NOT_FOUND, 24'h000000, 8'h00, 8'h00, 24'h000000, 7'h00, 1'b0}},
      '{mk(REQ_START, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
        '{ST_READ, 24'h000104, 8'h00, 8'h00, 24'h000000, 7'h00, 1'b0}},
      // deleted entry of the longest payload
      '{mk(REQ_HEADER, 8'h00, 8'h00, 8'hff, 8'h00), 1'b0, NO_RESULT},
      // highest key id, taken as the sought id
      '{mk(REQ_HEADER, 8'h00, 8'hff, 8'h00, 8'h7f), 1'b0, NO_RESULT},
      '{mk(REQ_RESUME, 8'hff, 8'h00, 8'h00, 8'h00), 1'b0, NO_RESULT},
      '{mk(REQ_HEADER, 8'h00, 8'h00, 8'h01, 8'hff), 1'b0, NO_RESULT},
      '{mk(REQ_RESUME, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, NO_RESULT},
      '{mk(REQ_HEADER, 8'h00, 8'h01, 8'h03, 8'h40), 1'b0, NO_RESULT},
      '{mk(REQ_RESUME, 8'h41, 8'h00, 8'h00, 8'h00), 1'b0, NO_RESULT},
      '{mk(REQ_HEADER, 8'h00, 8'h03, 8'h02, 8'h01), 1'b0, NO_RESULT},
      '{mk(REQ_HEADER, 8'h00, 8'h02, 8'h80, 8'hc0), 1'b0, NO_RESULT},
      '{mk(REQ_HEADER, 8'h00, 8'h80, 8'h7f, 8'h81), 1'b0, NO_RESULT},
      // broken back-length
      '{mk(REQ_HEADER, 8'h00, 8'h00, 8'haa, 8'h55), 1'b1,
        '{ST_CORRUPT, 24'h000400, 8'haa, 8'h55, 24'h000104, 7'h7f, 1'b0}},
      '{mk(REQ_RESUME, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
        '{ST_NOT_FOUND, 24'h000400, 8'h00, 8'h00, 24'h000104, 7'h7f, 1'b0}},
      '{mk(REQ_START, 8'h09, 8'h00, 8'h00, 8'h00), 1'b1,
        '{ST_READ, 24'h000104, 8'h00, 8'h00, 24'h000000, 7'h00, 1'b0}},
      // resume and restart while a read is outstanding
      '{mk(REQ_RESUME, 8'h0a, 8'h00, 8'h00, 8'h00), 1'b1,
        '{ST_READ, 24'h000104, 8'h00, 8'h00, 24'h000000, 7'h00, 1'b0}},
      '{mk(REQ_START, 8'h0a, 8'h00, 8'h00, 8'h00), 1'b1,
        '{ST_READ, 24'h000104, 8'h00, 8'h00, 24'h000000, 7'h00, 1'b0}},
      '{mk(REQ_HEADER, 8'h00, 8'h00, 8'h08, 8'h09), 1'b0, NO_RESULT},
      '{mk(REQ_HEADER, 8'h00, 8'h08, 8'h10, 8'h0a), 1'b0, NO_RESULT},
      // stray header after the match
      '{mk(REQ_HEADER, 8'h3c, 8'h10, 8'h10, 8'h0a), 1'b0, NO_RESULT},
      '{mk(REQ_UNUSED, 8'h55, 8'haa, 8'h55, 8'haa), 1'b0, NO_RESULT}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_CFG_ROW) set_window(24'h000100, 24'h000400);
      push_request(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res, has);
    end

    // random phases over several scan windows, extremes among them
    base = 24'($urandom_range(0, 24'hff0000));
    set_window(base, base + 24'($urandom_range(256, 4096)));
    run_random_phase(per_phase, 1'b1);

    // no idling on either side through this phase
    set_window(24'h000000, 24'hffffff);
    calm = 1'b1;
    run_random_phase(per_phase, 1'b0);
    calm = 1'b0;

    set_window(24'hffffff, 24'h000000);
    run_random_phase(per_phase, 1'b0);

    fill_reclaim();

    set_window(24'hffff00, 24'hffffff);
    run_random_phase(per_phase, 1'b0);

    set_window(24'($urandom), 24'($urandom));
    run_random_phase(per_phase, 1'b0);

    base = 24'($urandom_range(0, 24'hff0000));
    set_window(base, base + 24'($urandom_range(256, 4096)));
    run_random_phase(per_phase, 1'b0);

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/fkvs_pkg.sv
rtl/core/fkvs_cfg_regs.sv
rtl/core/fkvs_in_reg.sv
rtl/core/fkvs_scan_core.sv
rtl/core/flash_kv_log_header_scanner_top.sv
dv/tb_flash_kv_log_header_scanner_top.sv
